@@ src/bse_pkg.sv @@
// shared types and constants for the bubble sort engine
`default_nettype none

package bse_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        value_t in_value;
        logic   in_last;
    } in_item_t;

    typedef struct packed {
        value_t out_value;
        logic   out_last;
        logic   out_overflow;
    } out_item_t;

    // outcome of one compare-swap step of a pass
    typedef struct packed {
        value_t wr_value;
        value_t carry;
    } cs_result_t;

endpackage

`default_nettype wire

@@ src/bse_cmp_swap.sv @@
// compare-swap unit shared by every step of every sort pass
`default_nettype none

module bse_cmp_swap
    import bse_pkg::*;
(
    input  value_t     carry,
    input  value_t     incoming,
    output cs_result_t result
);

    logic greater;

    // equal values never swap, which keeps the order stable
    assign greater = carry > incoming;

    always_comb begin
        if (greater) begin
            result.wr_value = incoming;
            result.carry    = carry;
        end else begin
            result.wr_value = carry;
            result.carry    = incoming;
        end
    end

endmodule

`default_nettype wire

@@ src/bubble_sort_engine_unit.sv @@
// top level of the bubble sort engine: element store, pass sequencer and output register
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_valid / s_ready | s_data  (in_item_t: in_value, in_last)
//  m_      | out | m_valid / m_ready | m_data  (out_item_t: out_value, out_last, out_overflow)
//
// loading takes one item per cycle; items past CAPACITY are dropped and flag overflow
// after the last item of a set, the passes over the n held elements run
// one compare-swap per cycle through the single store port pair, then each
// result is read out of the store and held in the output register until m_ready
// s_ready is low from the last item of a set until its last result is taken
// aresetn (synchronous) empties the store; its contents are only read after being written
`default_nettype none

module bubble_sort_engine_unit
    import bse_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PRIME,
        ST_FIRST,
        ST_PASS,
        ST_TAIL,
        ST_ORD,
        ST_OLOAD,
        ST_OWAIT
    } state_t;

    state_t             state_reg,   state_next;
    logic [CNT_W-1:0]   count_reg,   count_next;
    logic [CNT_W-1:0]   n_reg,       n_next;
    logic               ovf_reg,     ovf_next;
    logic [IDX_W-1:0]   k_reg,       k_next;
    logic [IDX_W-1:0]   end_reg,     end_next;
    logic [IDX_W-1:0]   oidx_reg,    oidx_next;
    value_t             carry_reg,   carry_next;
    logic               mvalid_reg,  mvalid_next;
    out_item_t          out_reg,     out_next;

    value_t             mem [CAPACITY];
    value_t             rdata_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    value_t             mem_wdata;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;

    logic               fits;
    logic [CNT_W-1:0]   n_val;
    cs_result_t         cs;

    bse_cmp_swap u_cmp_swap (
        .carry    (carry_reg),
        .incoming (rdata_reg),
        .result   (cs)
    );

    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = mvalid_reg;
    assign m_data  = out_reg;

    assign fits  = count_reg < CNT_W'(CAPACITY);
    assign n_val = fits ? count_reg + CNT_W'(1) : count_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        n_next      = n_reg;
        ovf_next    = ovf_reg;
        k_next      = k_reg;
        end_next    = end_reg;
        oidx_next   = oidx_reg;
        carry_next  = carry_reg;
        mvalid_next = mvalid_reg;
        out_next    = out_reg;
        mem_we      = 1'b0;
        mem_waddr   = k_reg - IDX_W'(1);
        mem_wdata   = cs.wr_value;
        rd_en       = 1'b0;
        rd_addr     = '0;

        case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    if (fits) begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[IDX_W-1:0];
                        mem_wdata  = s_data.in_value;
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_data.in_last) begin
                        n_next    = n_val;
                        end_next  = IDX_W'(n_val - CNT_W'(1));
                        oidx_next = '0;
                        if (n_val > CNT_W'(1)) begin
                            state_next = ST_PRIME;
                        end else begin
                            state_next = ST_ORD;
                        end
                    end
                end
            end
            ST_PRIME: begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = ST_FIRST;
            end
            ST_FIRST: begin
                carry_next = rdata_reg;
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(1);
                k_next     = IDX_W'(1);
                state_next = ST_PASS;
            end
            ST_PASS: begin
                // the larger value rides along as carry, the smaller drops in behind it
                mem_we     = 1'b1;
                carry_next = cs.carry;
                if (k_reg == end_reg) begin
                    state_next = ST_TAIL;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = k_reg + IDX_W'(1);
                    k_next  = k_reg + IDX_W'(1);
                end
            end
            ST_TAIL: begin
                mem_we    = 1'b1;
                mem_waddr = end_reg;
                mem_wdata = carry_reg;
                if (end_reg > IDX_W'(1)) begin
                    end_next   = end_reg - IDX_W'(1);
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = ST_FIRST;
                end else begin
                    oidx_next  = '0;
                    state_next = ST_ORD;
                end
            end
            ST_ORD: begin
                rd_en      = 1'b1;
                rd_addr    = oidx_reg;
                state_next = ST_OLOAD;
            end
            ST_OLOAD: begin
                out_next.out_value    = rdata_reg;
                out_next.out_last     = (CNT_W'(oidx_reg) + CNT_W'(1)) == n_reg;
                out_next.out_overflow = ovf_reg;
                mvalid_next           = 1'b1;
                state_next            = ST_OWAIT;
            end
            ST_OWAIT: begin
                if (m_ready) begin
                    mvalid_next = 1'b0;
                    if (out_reg.out_last) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = oidx_reg + IDX_W'(1);
                        oidx_next  = oidx_reg + IDX_W'(1);
                        state_next = ST_OLOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            mvalid_reg <= mvalid_next;
        end
        n_reg     <= n_next;
        k_reg     <= k_next;
        end_reg   <= end_next;
        oidx_reg  <= oidx_next;
        carry_reg <= carry_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire
